// File: hdl/polyphase_rational_resampler_macros.svh
// Assertion macros shared by the checker of the polyphase rational resampler.
`ifndef POLYPHASE_RATIONAL_RESAMPLER_MACROS_SVH
`define POLYPHASE_RATIONAL_RESAMPLER_MACROS_SVH

// Checks a condition in the same cycle as its trigger.
`define PRR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a condition in the cycle after its trigger.
`define PRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/prr_pkg.sv
// Package with the types and constants of the polyphase rational resampler.
`timescale 1ns / 1ps
`default_nettype none

package prr_pkg;

    localparam int MAX_TAPS_DEF   = 128;
    localparam int MAX_INTERP_DEF = 16;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_IDX_W = 7;
    localparam int ACTION_W   = 2;
    localparam int PHASE_W    = 9;
    localparam int TIDX_W     = 9;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 40;
    localparam int FRAC_BITS  = 15;

    localparam int CFG_L_W    = 5;
    localparam int CFG_M_W    = 8;
    localparam int CFG_T_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_COEF  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS   = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    typedef struct packed {
        logic [ACTION_W-1:0]          action;
        logic signed [SAMPLE_W-1:0]   sample_in;
        logic [COEF_IDX_W-1:0]        coef_index;
        logic signed [SAMPLE_W-1:0]   coef_value;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]   sample_out;
        logic                         last_of_run;
    } t_out_word;

endpackage

`default_nettype wire

// File: hdl/prr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module prr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/polyphase_rational_resampler.sv
// Top level of the polyphase rational resampler for Q15 samples.
//
// Input words carry an action: push a sample, write one coefficient, or clear
// the history and the phase. Each pushed sample yields zero or more output
// words; the last one of a run has last_of_run set. Configuration registers
// (interpolation, decimation, tap count) are written on a separate channel
// that is always ready and take effect at once, also during a sample in work.
// A coefficient write or a clear leaves the block idle. A sample whose phase is
// already at or past the interpolation factor yields no word: the check state
// lowers the phase and returns to idle. Otherwise every output issues one
// product per tap of its branch, roughly tap_count / interp_factor of them,
// then drains the multiply-accumulate pipeline and saturates before the word
// shows. One shared 16x16 multiplier feeds a 40-bit accumulator.
// The input is not ready while a sample is in work or a word is waiting.
// A stalled receiver holds the block with the word stable on the output.
// Reset sets the registers to 1, clears the phase and empties the history
// through a fill count, so no clearing pass is needed. Coefficients are not
// reset and must be written before use.
`timescale 1ns / 1ps
`default_nettype none

module polyphase_rational_resampler #(
    parameter int MAX_TAPS   = prr_pkg::MAX_TAPS_DEF,
    parameter int MAX_INTERP = prr_pkg::MAX_INTERP_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire prr_pkg::t_in_word                 i_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output prr_pkg::t_out_word                     o_out,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [prr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [prr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import prr_pkg::*;

    localparam int AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int FW  = $clog2(MAX_TAPS + 1);
    localparam int Q_W = ACC_W - FRAC_BITS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);
    localparam logic [FW-1:0] FULL      = FW'(MAX_TAPS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_RUN   = 6'b000100,
        S_DRAIN = 6'b001000,
        S_SAT   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                    r_state, n_state;
    logic [CFG_L_W-1:0]        r_cfg_l;
    logic [CFG_M_W-1:0]        r_cfg_m;
    logic [CFG_T_W-1:0]        r_cfg_t;
    logic [PHASE_W-1:0]        r_phase, n_phase;
    logic [AW-1:0]             r_wptr, n_wptr;
    logic [FW-1:0]             r_fill, n_fill;
    logic [TIDX_W-1:0]         r_t, n_t;
    logic [FW-1:0]             r_i, n_i;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_v1, r_hz1, r_v2;
    t_out_word                 r_out, n_out;

    logic [CFG_L_W-1:0]        w_l;
    logic [CFG_M_W-1:0]        w_m;
    logic [CFG_T_W-1:0]        w_t;
    logic                      w_in_acc;
    logic                      w_issue;
    logic [AW-1:0]             w_wptr_inc;
    logic [AW-1:0]             w_hidx;
    logic [AW-1:0]             w_haddr;
    logic                      w_coef_we;
    logic [SAMPLE_W-1:0]       w_coef_rd;
    logic [SAMPLE_W-1:0]       w_hist_rd;
    logic signed [SAMPLE_W-1:0] w_hist_op;
    logic signed [Q_W-1:0]     w_q;
    logic signed [SAMPLE_W-1:0] w_sat;
    logic [PHASE_W-1:0]        w_phase_adv;

    always_comb begin
        if (r_cfg_l == '0) begin
            w_l = CFG_L_W'(1);
        end else if (int'(r_cfg_l) > MAX_INTERP) begin
            w_l = CFG_L_W'(MAX_INTERP);
        end else begin
            w_l = r_cfg_l;
        end
        w_m = (r_cfg_m == '0) ? CFG_M_W'(1) : r_cfg_m;
        w_t = (int'(r_cfg_t) > MAX_TAPS) ? CFG_T_W'(MAX_TAPS) : r_cfg_t;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_state == S_OUT);
    assign o_out       = r_out;
    assign w_in_acc    = i_in_valid && o_in_ready;

    assign w_issue    = (r_state == S_RUN) && (r_t < TIDX_W'(w_t));
    assign w_wptr_inc = (r_wptr == LAST_ADDR) ? '0 : r_wptr + AW'(1);
    assign w_hidx     = r_i[AW-1:0];
    assign w_haddr    = (r_wptr >= w_hidx) ? r_wptr - w_hidx
                                           : r_wptr + (LAST_ADDR - w_hidx) + AW'(1);
    assign w_coef_we  = w_in_acc && (i_in.action == ACT_COEF)
                        && (int'(i_in.coef_index) < MAX_TAPS);
    assign w_hist_op  = r_hz1 ? $signed(w_hist_rd) : '0;

    assign w_q         = r_acc[ACC_W-1:FRAC_BITS];
    assign w_phase_adv = r_phase + PHASE_W'(w_m);

    always_comb begin
        if (w_q > Q_W'(SAT_MAX)) begin
            w_sat = SAT_MAX;
        end else if (w_q < Q_W'(SAT_MIN)) begin
            w_sat = SAT_MIN;
        end else begin
            w_sat = w_q[SAMPLE_W-1:0];
        end
    end

    prr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (AW'(i_in.coef_index)),
        .i_wdata (i_in.coef_value),
        .i_raddr (AW'(r_t)),
        .o_rdata (w_coef_rd)
    );

    prr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && (i_in.action == ACT_PUSH)),
        .i_waddr (w_wptr_inc),
        .i_wdata (i_in.sample_in),
        .i_raddr (w_haddr),
        .o_rdata (w_hist_rd)
    );

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_wptr  = r_wptr;
        n_fill  = r_fill;
        n_t     = r_t;
        n_i     = r_i;
        n_acc   = r_acc;
        n_out   = r_out;
        if (r_v2) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_in.action)
                        ACT_PUSH: begin
                            n_wptr = w_wptr_inc;
                            if (r_fill != FULL) begin
                                n_fill = r_fill + FW'(1);
                            end
                            n_state = S_CHECK;
                        end
                        ACT_CLEAR: begin
                            n_fill  = '0;
                            n_phase = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (r_phase < PHASE_W'(w_l)) begin
                    n_t     = TIDX_W'(r_phase);
                    n_i     = '0;
                    n_acc   = '0;
                    n_state = S_RUN;
                end else begin
                    n_phase = r_phase - PHASE_W'(w_l);
                    n_state = S_IDLE;
                end
            end
            S_RUN: begin
                if (w_issue) begin
                    n_t = r_t + TIDX_W'(w_l);
                    n_i = r_i + FW'(1);
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                n_out.sample_out  = w_sat;
                n_out.last_of_run = (w_phase_adv >= PHASE_W'(w_l));
                n_phase           = w_phase_adv;
                n_state           = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_out.last_of_run) begin
                        n_phase = r_phase - PHASE_W'(w_l);
                        n_state = S_IDLE;
                    end else begin
                        n_t     = TIDX_W'(r_phase);
                        n_i     = '0;
                        n_acc   = '0;
                        n_state = S_RUN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= '0;
            r_wptr  <= '0;
            r_fill  <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_cfg_l <= CFG_L_W'(1);
            r_cfg_m <= CFG_M_W'(1);
            r_cfg_t <= CFG_T_W'(1);
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_wptr  <= n_wptr;
            r_fill  <= n_fill;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_INTERP: r_cfg_l <= i_cfg_data[CFG_L_W-1:0];
                    CFG_DECIM:  r_cfg_m <= i_cfg_data[CFG_M_W-1:0];
                    CFG_TAPS:   r_cfg_t <= i_cfg_data[CFG_T_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t    <= n_t;
        r_i    <= n_i;
        r_acc  <= n_acc;
        r_out  <= n_out;
        r_hz1  <= (r_i < r_fill);
        r_prod <= $signed(w_coef_rd) * w_hist_op;
    end

endmodule

`default_nettype wire

// File: hdl/prr_checker.sv
// Port-level checker for the polyphase rational resampler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "polyphase_rational_resampler_macros.svh"

module prr_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire prr_pkg::t_in_word  i_in,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire prr_pkg::t_out_word o_out
);

    import prr_pkg::*;

    // A pending output word blocks the input side.
    `PRR_ASSERT_SAME(a_busy_while_out, o_out_valid, !o_in_ready, "input ready while a word waits")

    // A stalled output word stays valid and unchanged.
    `PRR_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "stalled output word changed")

    // Coefficient writes and clears never produce an output word.
    `PRR_ASSERT_NEXT(a_ctrl_silent, i_in_valid && o_in_ready && (i_in.action != ACT_PUSH), !o_out_valid, "output word after a non-sample input")

    // A word that does not end its run keeps the block busy.
    `PRR_ASSERT_NEXT(a_run_continues, o_out_valid && i_out_ready && !o_out.last_of_run, !o_in_ready, "input ready before the run ended")

endmodule

bind polyphase_rational_resampler prr_checker u_prr_checker (.*);

`default_nettype wire

// File: bench/tb_polyphase_rational_resampler.sv
// Self-checking testbench for the polyphase rational resampler with a predicting scoreboard.
`timescale 1ns / 1ps

class q15_resample_tracker;
    shortint history[prr_pkg::MAX_TAPS_DEF];
    shortint coef_store[prr_pkg::MAX_TAPS_DEF];
    bit [prr_pkg::PHASE_W-1:0] phase;
    bit [prr_pkg::CFG_L_W-1:0] interp;
    bit [prr_pkg::CFG_M_W-1:0] decim;
    bit [prr_pkg::CFG_T_W-1:0] taps;
    prr_pkg::t_out_word pending_outputs[$];
    int failures;
    int samples;
    int coef_writes;
    int clears;
    int ignored;
    int reg_writes;
    int words_checked;

    function new();
        foreach (history[i]) begin
            history[i] = 0;
            coef_store[i] = 0;
        end
        phase = '0;
        interp = 1;
        decim = 1;
        taps = 1;
        failures = 0;
        samples = 0;
        coef_writes = 0;
        clears = 0;
        ignored = 0;
        reg_writes = 0;
        words_checked = 0;
    endfunction

    function void report(string msg);
        failures++;
        if (failures <= 10) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endfunction

    function void set_register(logic [prr_pkg::CFG_IDX_W-1:0] idx,
                               logic [prr_pkg::CFG_DATA_W-1:0] data);
        reg_writes++;
        case (idx)
            prr_pkg::CFG_INTERP: interp = data[prr_pkg::CFG_L_W-1:0];
            prr_pkg::CFG_DECIM:  decim = data;
            prr_pkg::CFG_TAPS:   taps = data;
            default: ;
        endcase
    endfunction

    function logic [prr_pkg::SAMPLE_W-1:0] branch_dot(int ph, int step, int ntaps);
        longint acc;
        longint q;
        int i;
        int t;
        acc = 0;
        i = 0;
        t = ph;
        while (t < ntaps && i < prr_pkg::MAX_TAPS_DEF) begin
            acc += longint'(history[i]) * longint'(coef_store[t]);
            i++;
            t += step;
        end
        q = acc >>> prr_pkg::FRAC_BITS;
        if (q > longint'(prr_pkg::SAT_MAX)) begin
            return prr_pkg::SAT_MAX;
        end
        if (q < longint'(prr_pkg::SAT_MIN)) begin
            return prr_pkg::SAT_MIN;
        end
        return q[prr_pkg::SAMPLE_W-1:0];
    endfunction

    function void accept_word(prr_pkg::t_in_word w);
        int l;
        int m;
        int n;
        int ph;
        int k;
        prr_pkg::t_out_word e;
        case (w.action)
            prr_pkg::ACT_COEF: begin
                coef_writes++;
                coef_store[w.coef_index] = w.coef_value;
            end
            prr_pkg::ACT_CLEAR: begin
                clears++;
                foreach (history[i]) begin
                    history[i] = 0;
                end
                phase = '0;
            end
            prr_pkg::ACT_PUSH: begin
                samples++;
                l = (interp == 0) ? 1 :
                    (interp > prr_pkg::MAX_INTERP_DEF) ? prr_pkg::MAX_INTERP_DEF : interp;
                m = (decim == 0) ? 1 : decim;
                n = (taps > prr_pkg::MAX_TAPS_DEF) ? prr_pkg::MAX_TAPS_DEF : taps;
                for (k = prr_pkg::MAX_TAPS_DEF - 1; k > 0; k--) begin
                    history[k] = history[k-1];
                end
                history[0] = w.sample_in;
                ph = phase;
                while (ph < l) begin
                    e.sample_out = branch_dot(ph, l, n);
                    e.last_of_run = (ph + m >= l);
                    pending_outputs.push_back(e);
                    ph += m;
                end
                phase = ph - l;
            end
            default: ignored++;
        endcase
    endfunction

    function void check_output_word(prr_pkg::t_out_word got);
        prr_pkg::t_out_word e;
        if (pending_outputs.size() == 0) begin
            report($sformatf("unexpected output word: sample_out=%0d last_of_run=%0b",
                             $signed(got.sample_out), got.last_of_run));
            return;
        end
        e = pending_outputs.pop_front();
        words_checked++;
        if (got.sample_out !== e.sample_out) begin
            report($sformatf("output word %0d: sample_out expected %0d, got %0d",
                             words_checked, $signed(e.sample_out), $signed(got.sample_out)));
        end
        if (got.last_of_run !== e.last_of_run) begin
            report($sformatf("output word %0d: last_of_run expected %0b, got %0b",
                             words_checked, e.last_of_run, got.last_of_run));
        end
    endfunction

    function int pending();
        return pending_outputs.size();
    endfunction

    function void flush_missing();
        prr_pkg::t_out_word e;
        while (pending_outputs.size() != 0) begin
            e = pending_outputs.pop_front();
            report($sformatf("output word never arrived: sample_out=%0d last_of_run=%0b",
                             $signed(e.sample_out), e.last_of_run));
        end
    endfunction
endclass

module tb_polyphase_rational_resampler;
    import prr_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int IDLE_PCT        = 29;
    localparam int SETTLE_CYCLES   = 160;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_PHASES   = 12;
    localparam int WORDS_PER_PHASE = 13;

    localparam logic [ACTION_W-1:0]  ACT_NONE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_word              i_in;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    q15_resample_tracker tracker = new();
    int idle_cycles = 0;
    bit no_idle = 1'b0;
    int settings_used = 0;

    polyphase_rational_resampler u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                tracker.check_output_word(o_out);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] rand_q15();
        case ($urandom_range(0, 9))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2, 3: return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_word push_word(logic [SAMPLE_W-1:0] s);
        t_in_word w;
        w.action = ACT_PUSH;
        w.sample_in = s;
        w.coef_index = 7'($urandom);
        w.coef_value = 16'($urandom);
        return w;
    endfunction

    function automatic t_in_word coef_word(logic [COEF_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] v);
        t_in_word w;
        w.action = ACT_COEF;
        w.sample_in = 16'($urandom);
        w.coef_index = idx;
        w.coef_value = v;
        return w;
    endfunction

    function automatic t_in_word ctrl_word(logic [ACTION_W-1:0] act);
        t_in_word w;
        w.action = act;
        w.sample_in = 16'($urandom);
        w.coef_index = 7'($urandom);
        w.coef_value = 16'($urandom);
        return w;
    endfunction

    function automatic t_in_word random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 84) begin
            return push_word(rand_q15());
        end
        if (pick < 94) begin
            return coef_word(7'($urandom_range(0, 127)), rand_q15());
        end
        if (pick < 97) begin
            return ctrl_word(ACT_CLEAR);
        end
        return ctrl_word(ACT_NONE);
    endfunction

    task automatic send_word(input t_in_word w);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= w;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.accept_word(w);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_register(idx, data);
    endtask

    // The block must be idle before the registers change.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] l,
                                  input logic [CFG_DATA_W-1:0] m,
                                  input logic [CFG_DATA_W-1:0] t);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (settings_used == 0) begin
            write_cfg(CFG_SPARE, 8'hFF);
        end
        write_cfg(CFG_INTERP, l);
        write_cfg(CFG_DECIM, m);
        write_cfg(CFG_TAPS, t);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic random_settings();
        logic [CFG_DATA_W-1:0] l;
        logic [CFG_DATA_W-1:0] m;
        logic [CFG_DATA_W-1:0] t;
        l = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 16));
        m = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 12));
        t = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 48));
        apply_settings(l, m, t);
    endtask

    initial begin
        int k;
        int p;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every tap gets a value before any sample can read it.
        for (k = 0; k < MAX_TAPS_DEF; k++) begin
            send_word(coef_word(7'(k), rand_q15()));
        end

        // Reset settings: one tap, so each output is a single product.
        send_word(coef_word(7'd0, SAT_MIN));
        send_word(push_word(SAT_MIN));
        send_word(push_word(SAT_MAX));
        send_word(push_word(16'd0));
        send_word(push_word(16'hFFFF));
        send_word(coef_word(7'd0, SAT_MAX));
        send_word(push_word(16'hFFFF));
        send_word(push_word(16'd1));
        send_word(ctrl_word(ACT_NONE));

        // The upper bits of the interpolation write fall outside the register.
        apply_settings(8'hE3, 8'd2, 8'd12);
        send_word(coef_word(7'd127, SAT_MAX));
        send_word(push_word(SAT_MAX));
        send_word(push_word(SAT_MAX));
        send_word(push_word(SAT_MIN));
        send_word(ctrl_word(ACT_CLEAR));
        send_word(push_word(16'd12345));

        apply_settings(8'd0, 8'd0, 8'd0);
        send_word(push_word(rand_q15()));
        send_word(push_word(rand_q15()));

        apply_settings(8'd31, 8'd1, 8'd200);
        send_word(push_word(SAT_MAX));
        send_word(push_word(SAT_MIN));

        // A large decimation leaves most samples without an output.
        apply_settings(8'd2, 8'd255, 8'd128);
        send_word(push_word(rand_q15()));
        send_word(push_word(rand_q15()));
        send_word(push_word(rand_q15()));
        send_word(ctrl_word(ACT_CLEAR));
        send_word(push_word(rand_q15()));

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: apply_settings(8'd16, 8'd1, 8'd128);
                1: apply_settings(8'd1, 8'd255, 8'd128);
                2: apply_settings(8'd1, 8'd1, 8'd1);
                3: apply_settings(8'd16, 8'd255, 8'd1);
                default: random_settings();
            endcase
            no_idle <= (p == 5 || p == 6);
            for (k = 0; k < WORDS_PER_PHASE; k++) begin
                send_word(random_word());
            end
        end

        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        tracker.flush_missing();

        $display("Sent %0d samples, %0d coefficient writes, %0d clears, %0d ignored words",
                 tracker.samples, tracker.coef_writes, tracker.clears, tracker.ignored);
        $display("over %0d register settings; %0d output words checked, %0d failures.",
                 settings_used, tracker.words_checked, tracker.failures);
        if (tracker.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
